### rtl/rvx_pkg.sv
// rvx_pkg: shared types, encodings and sizes of the instruction executor
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rvx_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned NREGS      = 32;
  localparam int unsigned RIDX_W     = $clog2(NREGS);
  localparam int unsigned DATA_BYTES = 1024;
  localparam int unsigned DADDR_W    = $clog2(DATA_BYTES);
  localparam int unsigned LANES      = 4;
  localparam int unsigned LANE_W     = $clog2(LANES);
  localparam int unsigned ROW_W      = DADDR_W - LANE_W;
  localparam int unsigned ROWS       = DATA_BYTES / LANES;

  typedef enum logic [1:0] {
    OP_EXEC    = 2'd0,
    OP_WR_BYTE = 2'd1,
    OP_RD_BYTE = 2'd2,
    OP_RD_REG  = 2'd3
  } rvx_op_e;

  localparam logic [6:0] OPC_ALU    = 7'h33;
  localparam logic [6:0] OPC_ALUI   = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_HALT   = 7'h7F;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [2:0] F3_SW  = 3'd2;
  localparam logic [6:0] F7_SUB = 7'h20;

  // one input word, unpacked
  typedef struct packed {
    rvx_op_e             op;
    logic [XLEN-1:0]     instr;
    logic [DADDR_W-1:0]  baddr;
    logic [7:0]          bval;
    logic [RIDX_W-1:0]   ridx;
  } rvx_item_t;

  // data memory request, byte or big-endian word
  typedef struct packed {
    logic                en;
    logic                wr;
    logic                word;
    logic [DADDR_W-1:0]  addr;
    logic [XLEN-1:0]     wdata;
  } rvx_dreq_t;

  // execute stage result
  typedef struct packed {
    logic [XLEN-1:0]     npc;
    logic                halt;
    logic                wr;
    logic [RIDX_W-1:0]   rd;
    logic [XLEN-1:0]     res;
    logic                load;
  } rvx_xres_t;

endpackage

### rtl/rvx_regfile.sv
// rvx_regfile: 32 x 32 register file, two synchronous read ports, one write port
// depends on rvx_pkg; valid bits make unwritten registers read as zero
`timescale 1ns / 1ps

module rvx_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ren_i,
  input  logic [rvx_pkg::RIDX_W-1:0]    raddr1_i,
  input  logic [rvx_pkg::RIDX_W-1:0]    raddr2_i,
  input  logic                          wen_i,
  input  logic [rvx_pkg::RIDX_W-1:0]    waddr_i,
  input  logic [rvx_pkg::XLEN-1:0]      wdata_i,
  output logic [rvx_pkg::XLEN-1:0]      rdata1_o,
  output logic [rvx_pkg::XLEN-1:0]      rdata2_o
);
  import rvx_pkg::*;

  logic [XLEN-1:0]  bank1 [NREGS];
  logic [XLEN-1:0]  bank2 [NREGS];
  logic [NREGS-1:0] vld_q;
  logic [XLEN-1:0]  ram1_q, ram2_q, wd_q;
  logic             v1_q, v2_q, hit1_q, hit2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wen_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // both copies always written together, each feeds one read port
  always_ff @(posedge clk_i) begin
    if (wen_i) begin
      bank1[waddr_i] <= wdata_i;
      bank2[waddr_i] <= wdata_i;
    end
    if (ren_i) begin
      ram1_q <= bank1[raddr1_i];
      ram2_q <= bank2[raddr2_i];
      v1_q   <= vld_q[raddr1_i];
      v2_q   <= vld_q[raddr2_i];
      hit1_q <= wen_i && (waddr_i == raddr1_i);
      hit2_q <= wen_i && (waddr_i == raddr2_i);
      wd_q   <= wdata_i;
    end
  end

  // write in the read cycle wins over the old ram contents
  assign rdata1_o = hit1_q ? wd_q : (v1_q ? ram1_q : '0);
  assign rdata2_o = hit2_q ? wd_q : (v2_q ? ram2_q : '0);

endmodule

### rtl/rvx_dmem.sv
// rvx_dmem: byte data memory in four byte lanes, one access per lane a cycle
// depends on rvx_pkg; word accesses are big-endian and wrap round the end
`timescale 1ns / 1ps

module rvx_dmem (
  input  logic                     clk_i,
  input  rvx_pkg::rvx_dreq_t       req_i,
  output logic [rvx_pkg::XLEN-1:0] rword_o,
  output logic [7:0]               rbyte_o
);
  import rvx_pkg::*;

  logic [LANES-1:0][7:0] lane_rd;
  logic [LANE_W-1:0]     lane0_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [7:0]         mem [ROWS];
    logic [7:0]         rdata_q;
    logic [LANE_W-1:0]  idx;
    logic [DADDR_W-1:0] addr;
    logic [ROW_W-1:0]   row;
    logic               sel;
    logic [7:0]         wbyte;

    always_comb begin
      // byte position inside the word that lands in this lane
      idx   = LANE_W'(l) - req_i.addr[LANE_W-1:0];
      addr  = req_i.word ? (req_i.addr + DADDR_W'(idx)) : req_i.addr;
      row   = addr[DADDR_W-1:LANE_W];
      sel   = req_i.en && (req_i.word || (req_i.addr[LANE_W-1:0] == LANE_W'(l)));
      wbyte = req_i.word ? 8'(req_i.wdata >> {~idx, 3'b000}) : req_i.wdata[7:0];
    end

    always_ff @(posedge clk_i) begin
      if (sel) begin
        if (req_i.wr) begin
          mem[row] <= wbyte;
        end else begin
          rdata_q <= mem[row];
        end
      end
    end

    assign lane_rd[l] = rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && !req_i.wr) begin
      lane0_q <= req_i.addr[LANE_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rword_o[XLEN-1-8*i -: 8] = lane_rd[lane0_q + LANE_W'(i)];
    end
    rbyte_o = lane_rd[lane0_q];
  end

endmodule

### rtl/rvx_exec.sv
// rvx_exec: decode and execute of one word: alu, branch, jump, address generation
// depends on rvx_pkg; purely combinational, state lives in the top level
`timescale 1ns / 1ps

module rvx_exec (
  input  rvx_pkg::rvx_item_t       item_i,
  input  logic [rvx_pkg::XLEN-1:0] opa_i,
  input  logic [rvx_pkg::XLEN-1:0] opb_i,
  input  logic [rvx_pkg::XLEN-1:0] pc_i,
  input  logic                     halt_i,
  output rvx_pkg::rvx_xres_t       xres_o,
  output rvx_pkg::rvx_dreq_t       dreq_o
);
  import rvx_pkg::*;

  logic [6:0]      opc, f7;
  logic [2:0]      f3;
  logic [XLEN-1:0] immi, imms, immb, immj;
  logic [XLEN-1:0] alu_b, alu_res, pc4, ea;
  logic            sub, alu_ok;

  always_comb begin
    opc  = item_i.instr[6:0];
    f3   = item_i.instr[14:12];
    f7   = item_i.instr[31:25];
    immi = {{20{item_i.instr[31]}}, item_i.instr[31:20]};
    imms = {{20{item_i.instr[31]}}, item_i.instr[31:25], item_i.instr[11:7]};
    immb = {{19{item_i.instr[31]}}, item_i.instr[31], item_i.instr[7],
            item_i.instr[30:25], item_i.instr[11:8], 1'b0};
    immj = {{11{item_i.instr[31]}}, item_i.instr[31], item_i.instr[19:12],
            item_i.instr[20], item_i.instr[30:21], 1'b0};

    alu_b  = (opc == OPC_ALU) ? opb_i : immi;
    sub    = (opc == OPC_ALU) && (f3 == F3_ADD) && (f7 == F7_SUB);
    alu_ok = 1'b1;
    case (f3)
      F3_ADD:  alu_res = sub ? (opa_i - alu_b) : (opa_i + alu_b);
      F3_XOR:  alu_res = opa_i ^ alu_b;
      F3_OR:   alu_res = opa_i | alu_b;
      F3_AND:  alu_res = opa_i & alu_b;
      default: begin
        alu_res = '0;
        alu_ok  = 1'b0;
      end
    endcase

    pc4 = pc_i + XLEN'(4);
    ea  = opa_i + ((opc == OPC_STORE) ? imms : immi);

    xres_o.npc  = pc_i;
    xres_o.halt = halt_i;
    xres_o.wr   = 1'b0;
    xres_o.rd   = item_i.instr[11:7];
    xres_o.res  = alu_res;
    xres_o.load = 1'b0;

    dreq_o.en    = 1'b0;
    dreq_o.wr    = 1'b0;
    dreq_o.word  = 1'b0;
    dreq_o.addr  = item_i.baddr;
    dreq_o.wdata = {24'h0, item_i.bval};

    case (item_i.op)
      OP_WR_BYTE: begin
        dreq_o.en = 1'b1;
        dreq_o.wr = 1'b1;
      end
      OP_RD_BYTE: begin
        dreq_o.en = 1'b1;
      end
      OP_EXEC: begin
        // a halted core ignores further instructions
        if (!halt_i) begin
          xres_o.npc = pc4;
          case (opc)
            OPC_ALU, OPC_ALUI: xres_o.wr = alu_ok;
            OPC_LOAD: begin
              xres_o.wr   = 1'b1;
              xres_o.load = 1'b1;
              dreq_o.en   = 1'b1;
              dreq_o.word = 1'b1;
              dreq_o.addr = ea[DADDR_W-1:0];
            end
            OPC_STORE: begin
              if (f3 == F3_SW) begin
                dreq_o.en    = 1'b1;
                dreq_o.wr    = 1'b1;
                dreq_o.word  = 1'b1;
                dreq_o.addr  = ea[DADDR_W-1:0];
                dreq_o.wdata = opb_i;
              end
            end
            OPC_BRANCH: begin
              if (((f3 == F3_BEQ) && (opa_i == opb_i)) ||
                  ((f3 == F3_BNE) && (opa_i != opb_i))) begin
                xres_o.npc = pc_i + immb;
              end
            end
            OPC_JAL: begin
              xres_o.wr  = 1'b1;
              xres_o.res = pc4;
              xres_o.npc = pc_i + immj;
            end
            OPC_HALT: begin
              xres_o.halt = 1'b1;
              xres_o.npc  = pc_i;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // register zero is never written
    if (xres_o.rd == '0) begin
      xres_o.wr = 1'b0;
    end
    if (!xres_o.wr) begin
      xres_o.rd = '0;
    end
  end

endmodule

### rtl/rv32i_subset_instruction_executor.sv
// rv32i_subset_instruction_executor: top level, pipeline registers, pc and halt state
// depends on rvx_pkg, rvx_regfile, rvx_dmem and rvx_exec
`timescale 1ns / 1ps

// Usage:
// Each word on the s_axis channel is one operation selected by s_axis_tuser:
// execute the instruction in tdata, preload a data byte, read a data byte or
// read a register. Every accepted word yields exactly one word on m_axis with
// the pc to fetch next, the halt flag, read data and the register write.
// Instructions are fetched by the user at the last reported next pc.
// Pipeline: register read at accept, execute and data memory access in the
// next cycle, load data and register write-back in the one after, then the
// output register, which drives m_axis_tvalid. One word is accepted every cycle
// while no output word is held. Back-to-back dependencies are forwarded from
// the write-back stage and the register file bypass, so there are no bubbles.
// Reset clears the pc, the halt flag and all registers; data memory contents
// are undefined until preloaded. While an output word waits on m_axis_tready
// the whole pipeline holds and s_axis_tready drops with it.
module rv32i_subset_instruction_executor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [55:0]   s_axis_tdata,  // instr_word, byte_address, byte_value, reg_index
  input  logic [1:0]    s_axis_tuser,  // operation
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata   // next_pc, halted, read_value, reg_write,
                                       // dest_reg, write_value
);
  import rvx_pkg::*;

  logic               adv, accept;
  rvx_item_t          in_item;
  logic [RIDX_W-1:0]  in_rs1, in_rs2;

  logic               x_valid_q;
  rvx_item_t          x_item_q;
  logic [RIDX_W-1:0]  x_rs1, x_rs2;
  logic [XLEN-1:0]    rf_rd1, rf_rd2, opa, opb;
  rvx_xres_t          xres;
  rvx_dreq_t          xreq, dreq;

  logic [XLEN-1:0]    pc_q;
  logic               halt_q;

  logic               m_valid_q, m_halt_q, m_wr_q, m_load_q;
  rvx_op_e            m_op_q;
  logic [XLEN-1:0]    m_npc_q, m_res_q, m_rv_q, m_wval;
  logic [RIDX_W-1:0]  m_rd_q;
  logic [XLEN-1:0]    dm_rword;
  logic [7:0]         dm_rbyte;
  logic               rf_wen;

  logic               out_valid_q, out_halt_q, out_wr_q;
  logic [XLEN-1:0]    out_npc_q, out_rv_q, out_wval_q;
  logic [RIDX_W-1:0]  out_rd_q;
  logic [XLEN-1:0]    out_rv_d;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  always_comb begin
    in_item.op    = rvx_op_e'(s_axis_tuser);
    in_item.instr = s_axis_tdata[31:0];
    in_item.baddr = s_axis_tdata[41:32];
    in_item.bval  = s_axis_tdata[49:42];
    in_item.ridx  = s_axis_tdata[54:50];
    in_rs1 = (in_item.op == OP_RD_REG) ? in_item.ridx : in_item.instr[19:15];
    in_rs2 = in_item.instr[24:20];
  end

  rvx_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ren_i    (accept),
    .raddr1_i (in_rs1),
    .raddr2_i (in_rs2),
    .wen_i    (rf_wen),
    .waddr_i  (m_rd_q),
    .wdata_i  (m_wval),
    .rdata1_o (rf_rd1),
    .rdata2_o (rf_rd2)
  );

  // execute stage, forwarding from the write-back stage
  always_comb begin
    x_rs1 = (x_item_q.op == OP_RD_REG) ? x_item_q.ridx : x_item_q.instr[19:15];
    x_rs2 = x_item_q.instr[24:20];
    opa = (m_valid_q && m_wr_q && (m_rd_q == x_rs1)) ? m_wval : rf_rd1;
    opb = (m_valid_q && m_wr_q && (m_rd_q == x_rs2)) ? m_wval : rf_rd2;
  end

  rvx_exec u_exec (
    .item_i (x_item_q),
    .opa_i  (opa),
    .opb_i  (opb),
    .pc_i   (pc_q),
    .halt_i (halt_q),
    .xres_o (xres),
    .dreq_o (xreq)
  );

  always_comb begin
    dreq    = xreq;
    dreq.en = xreq.en && x_valid_q && adv;
  end

  rvx_dmem u_dmem (
    .clk_i   (clk_i),
    .req_i   (dreq),
    .rword_o (dm_rword),
    .rbyte_o (dm_rbyte)
  );

  assign m_wval = m_load_q ? dm_rword : m_res_q;
  assign rf_wen = m_valid_q && m_wr_q && adv;

  always_comb begin
    case (m_op_q)
      OP_RD_BYTE: out_rv_d = {24'h0, dm_rbyte};
      OP_RD_REG:  out_rv_d = m_rv_q;
      default:    out_rv_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
    end else if (adv) begin
      x_valid_q   <= s_axis_tvalid;
      m_valid_q   <= x_valid_q;
      out_valid_q <= m_valid_q;
      if (x_valid_q) begin
        pc_q   <= xres.npc;
        halt_q <= xres.halt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_item_q <= in_item;
    end
    if (adv && x_valid_q) begin
      m_op_q   <= x_item_q.op;
      m_npc_q  <= xres.npc;
      m_halt_q <= xres.halt;
      m_wr_q   <= xres.wr;
      m_rd_q   <= xres.rd;
      m_res_q  <= xres.res;
      m_load_q <= xres.load;
      m_rv_q   <= opa;
    end
    if (adv && m_valid_q) begin
      out_npc_q  <= m_npc_q;
      out_halt_q <= m_halt_q;
      out_rv_q   <= out_rv_d;
      out_wr_q   <= m_wr_q;
      out_rd_q   <= m_rd_q;
      out_wval_q <= m_wr_q ? m_wval : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_wval_q, out_rd_q, out_wr_q, out_rv_q,
                          out_halt_q, out_npc_q};

`ifndef NO_ASSERTIONS
  a_rf_no_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wen |-> (m_rd_q != '0))
    else $error("register zero written");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

  a_halt_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> (pc_q == $past(pc_q)))
    else $error("pc moved while halted");

  a_out_wr_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_wr_q) |-> ((out_rd_q == '0) && (out_wval_q == '0)))
    else $error("write fields set without a register write");
`endif

endmodule

### sim/tb.sv
// tb: self-checking bench for rv32i_subset_instruction_executor, one file
// builds instruction and data-access words, predicts each output word, checks them in order
// depends on rvx_pkg and the rtl of the executor
`timescale 1ns / 1ps

module tb;
  import rvx_pkg::*;

  // output word, last field in the lowest bits as on m_axis_tdata
  typedef struct packed {
    logic [XLEN-1:0]   write_value;
    logic [RIDX_W-1:0] dest_reg;
    logic              reg_write;
    logic [XLEN-1:0]   read_value;
    logic              halted;
    logic [XLEN-1:0]   next_pc;
  } retire_t;

  typedef struct {
    rvx_op_e            op;
    logic [XLEN-1:0]    instr;
    logic [DADDR_W-1:0] baddr;
    logic [7:0]         bval;
    logic [RIDX_W-1:0]  ridx;
    bit                 drain;  // hold until every earlier word has come back
  } issue_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;   // instr_word, byte_address, byte_value, reg_index
  logic [1:0]   s_axis_tuser = OP_EXEC;  // operation
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // next_pc, halted, read_value, reg_write,
                                     // dest_reg, write_value

  rv32i_subset_instruction_executor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // shadow of the executor state
  logic [XLEN-1:0] pc_m = '0;
  logic [XLEN-1:0] regs_m [NREGS];
  logic [7:0]      dmem_m [DATA_BYTES];
  bit              dmem_set [DATA_BYTES];
  bit              halted_m = 1'b0;

  issue_t             issue_q [$];
  retire_t            retire_q [$];
  logic [DADDR_W-1:0] word_addrs [$];  // starts of fully written 4-byte windows
  bit                 drain_next = 1'b0;
  int unsigned        n_issued = 0;
  int unsigned        n_retired = 0;
  int unsigned        n_op [4];
  int unsigned        n_taken = 0;
  int unsigned        n_writes = 0;
  int unsigned        errors = 0;
  int unsigned        gap_left = 0;
  int unsigned        stall_left = 0;
  bit                 s_burst = 1'b0;
  bit                 m_burst = 1'b0;

  function automatic bit alu_calc(input logic [2:0] f3, input logic [XLEN-1:0] a, b,
                                  input bit sub, output logic [XLEN-1:0] res);
    res = '0;
    case (f3)
      F3_ADD: res = sub ? a - b : a + b;
      F3_XOR: res = a ^ b;
      F3_OR:  res = a | b;
      F3_AND: res = a & b;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // advance the shadow state by one input word and return the output word it yields
  function automatic retire_t retire_item(issue_t it);
    retire_t            r;
    logic [6:0]         opc;
    logic [2:0]         f3;
    logic [6:0]         f7;
    logic [XLEN-1:0]    a, b, ins, immi, imms, immb, immj, res, npc, ea;
    logic [RIDX_W-1:0]  rd;
    logic [DADDR_W-1:0] idx;
    bit                 wr;
    r = '0;
    case (it.op)
      OP_WR_BYTE: begin
        dmem_m[it.baddr] = it.bval;
        dmem_set[it.baddr] = 1'b1;
      end
      OP_RD_BYTE: r.read_value = {24'd0, dmem_m[it.baddr]};
      OP_RD_REG:  r.read_value = regs_m[it.ridx];
      default: begin
        if (!halted_m) begin
          ins  = it.instr;
          opc  = ins[6:0];
          f3   = ins[14:12];
          f7   = ins[31:25];
          rd   = ins[11:7];
          a    = regs_m[ins[19:15]];
          b    = regs_m[ins[24:20]];
          immi = {{20{ins[31]}}, ins[31:20]};
          imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
          immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
          immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
          npc  = pc_m + 32'd4;
          res  = '0;
          wr   = 1'b0;
          case (opc)
            OPC_ALU:  wr = alu_calc(f3, a, b, f3 == F3_ADD && f7 == F7_SUB, res);
            OPC_ALUI: wr = alu_calc(f3, a, immi, 1'b0, res);
            OPC_LOAD: begin
              ea = a + immi;
              idx = ea[DADDR_W-1:0];
              // big-endian: lowest address is the top byte
              for (int k = 0; k < 4; k++) begin
                res = {res[23:0], dmem_m[idx]};
                idx++;
              end
              wr = 1'b1;
            end
            OPC_STORE: begin
              if (f3 == F3_SW) begin
                ea = a + imms;
                idx = ea[DADDR_W-1:0];
                for (int k = 0; k < 4; k++) begin
                  dmem_m[idx] = b[31:24];
                  dmem_set[idx] = 1'b1;
                  b = b << 8;
                  idx++;
                end
              end
            end
            OPC_BRANCH: begin
              if ((f3 == F3_BEQ && a == b) || (f3 == F3_BNE && a != b)) begin
                npc = pc_m + immb;
                n_taken++;
              end
            end
            OPC_JAL: begin
              res = pc_m + 32'd4;
              wr = 1'b1;
              npc = pc_m + immj;
            end
            OPC_HALT: begin
              halted_m = 1'b1;
              npc = pc_m;
            end
            default: ;
          endcase
          if (wr && rd != '0) begin
            regs_m[rd] = res;
            r.reg_write = 1'b1;
            r.dest_reg = rd;
            r.write_value = res;
            n_writes++;
          end
          pc_m = npc;
        end
      end
    endcase
    r.next_pc = pc_m;
    r.halted = halted_m;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [4:0] pick_rd();
    if ($urandom_range(0, 15) == 0) return 5'd0;
    return 5'($urandom_range(1, 31));
  endfunction

  function automatic logic [2:0] pick_f3();
    case ($urandom_range(0, 9))
      0, 1:    return F3_ADD;
      2, 3:    return F3_XOR;
      4, 5:    return F3_OR;
      6, 7:    return F3_AND;
      default: return 3'($urandom);
    endcase
  endfunction

  task automatic issue(rvx_op_e op, logic [31:0] instr, logic [DADDR_W-1:0] baddr,
                       logic [7:0] bval, logic [RIDX_W-1:0] ridx);
    issue_t it;
    it.op = op;
    it.instr = instr;
    it.baddr = baddr;
    it.bval = bval;
    it.ridx = ridx;
    it.drain = drain_next;
    drain_next = 1'b0;
    n_op[op]++;
    retire_q.push_back(retire_item(it));
    issue_q.push_back(it);
  endtask

  // unused fields carry random noise
  task automatic exec(logic [31:0] w);
    issue(OP_EXEC, w, DADDR_W'($urandom), 8'($urandom), RIDX_W'($urandom));
  endtask

  task automatic poke(logic [DADDR_W-1:0] addr, logic [7:0] val);
    issue(OP_WR_BYTE, $urandom, addr, val, RIDX_W'($urandom));
  endtask

  task automatic peek(logic [DADDR_W-1:0] addr);
    issue(OP_RD_BYTE, $urandom, addr, 8'($urandom), RIDX_W'($urandom));
  endtask

  task automatic read_reg(logic [RIDX_W-1:0] idx);
    issue(OP_RD_REG, $urandom, DADDR_W'($urandom), 8'($urandom), idx);
  endtask

  // byte reads only touch bytes that were written
  task automatic read_written_byte();
    logic [DADDR_W-1:0] a;
    a = DADDR_W'($urandom);
    for (int k = 0; k < 32 && !dmem_set[a]; k++) a = DADDR_W'($urandom);
    if (!dmem_set[a]) poke(a, 8'($urandom));
    peek(a);
  endtask

  task automatic gen_store(logic [2:0] f3);
    logic [4:0]      rs1;
    logic [11:0]     imm;
    logic [XLEN-1:0] ea;
    rs1 = 5'($urandom);
    imm = 12'($urandom);
    ea = regs_m[rs1] + {{20{imm[11]}}, imm};
    if (f3 == F3_SW && !halted_m) word_addrs.push_back(ea[DADDR_W-1:0]);
    exec(enc_s(imm, 5'($urandom), rs1, f3));
  endtask

  // pick the immediate so that the effective address lands on a written window
  task automatic gen_load(logic [DADDR_W-1:0] target);
    logic [4:0]         rs1;
    logic [1:0]         hi2;
    logic [DADDR_W-1:0] low;
    rs1 = 5'($urandom);
    hi2 = 2'($urandom);
    low = target - regs_m[rs1][DADDR_W-1:0];
    exec(enc_i({hi2, low}, rs1, 3'($urandom), pick_rd(), OPC_LOAD));
  endtask

  task automatic gen_random();
    int unsigned        sel;
    logic [4:0]         rs1, rs2;
    logic [6:0]         f7;
    logic [2:0]         f3;
    logic [12:0]        immb;
    logic [31:0]        w;
    logic [DADDR_W-1:0] base;
    sel = $urandom_range(0, 99);
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    f7 = ($urandom_range(0, 2) == 0) ? F7_SUB : 7'h00;
    if ($urandom_range(0, 7) == 0) f7 = 7'($urandom);
    if (sel < 20) begin
      exec(enc_r(f7, rs2, rs1, pick_f3(), pick_rd(), OPC_ALU));
    end else if (sel < 40) begin
      exec(enc_i(12'($urandom), rs1, pick_f3(), pick_rd(), OPC_ALUI));
    end else if (sel < 52) begin
      gen_load(word_addrs[$urandom_range(0, word_addrs.size() - 1)]);
    end else if (sel < 64) begin
      f3 = 3'($urandom);
      if ($urandom_range(0, 7) != 0) f3 = F3_SW;
      gen_store(f3);
    end else if (sel < 78) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: f3 = F3_BEQ;
        4, 5, 6, 7: f3 = F3_BNE;
        default:    f3 = 3'($urandom);
      endcase
      if ($urandom_range(0, 2) == 0) rs2 = rs1;
      immb = 13'($urandom);
      exec(enc_b(immb, rs2, rs1, f3));
    end else if (sel < 84) begin
      exec(enc_j(21'($urandom), pick_rd()));
    end else if (sel < 88) begin
      do
        w = $urandom;
      while (w[6:0] == OPC_ALU || w[6:0] == OPC_ALUI || w[6:0] == OPC_LOAD ||
             w[6:0] == OPC_STORE || w[6:0] == OPC_BRANCH || w[6:0] == OPC_JAL ||
             w[6:0] == OPC_HALT);
      exec(w);
    end else if (sel < 93) begin
      base = DADDR_W'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        // fill a word byte by byte, then load it back
        for (int k = 0; k < 4; k++) poke(base + DADDR_W'(k), 8'($urandom));
        word_addrs.push_back(base);
        gen_load(base);
      end else begin
        poke(base, 8'($urandom));
      end
    end else if (sel < 97) begin
      read_written_byte();
    end else begin
      read_reg(RIDX_W'($urandom));
    end
  endtask

  function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, what, exp_v, act_v);
    end
  endfunction

  // sender: one word at a time from issue_q, random gaps between words
  always @(posedge clk_i or negedge rst_ni) begin : drive
    issue_t      nx;
    bit          fire;
    int unsigned sent;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= OP_EXEC;
      n_issued <= 0;
      gap_left = 0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      sent = n_issued + 32'(fire);
      if (fire) begin
        n_issued <= sent;
        gap_left = s_burst ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 29) == 0) s_burst = !s_burst;
      end
      if (s_axis_tvalid && !fire) begin
        // word still waiting, hold it
      end else if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (issue_q.size() != 0 && (!issue_q[0].drain || n_retired == sent)) begin
        nx = issue_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, nx.ridx, nx.bval, nx.baddr, nx.instr};
        s_axis_tuser <= nx.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls after each word, compare against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : observe
    retire_t got, want;
    logic    rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      n_retired <= 0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[102:0];
        n_retired <= n_retired + 1;
        if (retire_q.size() == 0) begin
          errors++;
          $display("%0t: output word with nothing pending: %h", $time, m_axis_tdata);
        end else begin
          want = retire_q.pop_front();
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("halted", 32'(want.halted), 32'(got.halted));
          check_field("read_value", want.read_value, got.read_value);
          check_field("reg_write", 32'(want.reg_write), 32'(got.reg_write));
          check_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
          check_field("write_value", want.write_value, got.write_value);
        end
        stall_left = m_burst ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 29) == 0) m_burst = !m_burst;
      end
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  initial begin : run
    int unsigned n_total;
    int unsigned next_drain;
    for (int i = 0; i < NREGS; i++) regs_m[i] = '0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      dmem_m[i] = '0;
      dmem_set[i] = 1'b0;
    end

    // directed: field extremes, each instruction kind and the corner cases
    read_reg(5'd0);
    exec(32'h0000_0000);                                  // opcode zero does nothing
    exec(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd1, OPC_ALUI));   // x1 = all ones
    exec(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd2, OPC_ALUI));
    exec(enc_r(7'h00, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_ALU));
    exec(enc_r(F7_SUB, 5'd1, 5'd2, F3_ADD, 5'd4, OPC_ALU));
    exec(enc_r(7'h7F, 5'd2, 5'd1, F3_ADD, 5'd5, OPC_ALU));   // odd funct7 still adds
    exec(enc_r(F7_SUB, 5'd2, 5'd1, F3_XOR, 5'd6, OPC_ALU));  // sub funct7 ignored off funct3 0
    exec(enc_r(7'h00, 5'd4, 5'd1, F3_OR, 5'd7, OPC_ALU));
    exec(enc_r(7'h00, 5'd2, 5'd1, 3'd1, 5'd9, OPC_ALU));     // unsupported funct3, no write
    exec(enc_i(12'h555, 5'd1, F3_XOR, 5'd12, OPC_ALUI));
    exec(enc_i(12'h800, 5'd2, F3_AND, 5'd13, OPC_ALUI));
    exec(enc_i(12'h123, 5'd1, 3'd5, 5'd15, OPC_ALUI));       // unsupported funct3
    exec(enc_i(12'h005, 5'd1, F3_ADD, 5'd0, OPC_ALUI));      // x0 destination
    poke(10'd1022, 8'h12);
    poke(10'd1023, 8'hFF);
    poke(10'd0, 8'h00);
    poke(10'd1, 8'h34);
    word_addrs.push_back(10'd1022);
    peek(10'd1023);
    exec(enc_i(12'd1022, 5'd0, 3'd7, 5'd10, OPC_LOAD));      // wraps the top, funct3 ignored
    exec(enc_s(12'hFFE, 5'd1, 5'd0, 3'd0));                  // funct3 0 stores nothing
    exec(enc_s(12'hFFE, 5'd2, 5'd0, F3_SW));
    exec(enc_i(12'hFFE, 5'd0, F3_ADD, 5'd11, OPC_LOAD));
    exec(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ));               // taken backwards past zero
    exec(enc_b(13'h0FFE, 5'd2, 5'd1, F3_BNE));
    exec(enc_b(13'h0008, 5'd0, 5'd0, 3'd5));                 // other funct3 never branches
    exec(enc_j(21'h100000, 5'd31));
    read_reg(5'd31);

    drain_next = 1'b1;
    next_drain = issue_q.size() + 200;
    while (issue_q.size() < 750) begin
      if (issue_q.size() > next_drain) begin
        drain_next = 1'b1;
        next_drain += 200;
      end
      gen_random();
    end

    // halt is sticky until reset, so it closes the run
    drain_next = 1'b1;
    exec(enc_i(12'($urandom), 5'($urandom), 3'($urandom), 5'($urandom), OPC_HALT));
    exec(32'hFFFF_FFFF);
    repeat (8) gen_random();
    read_reg(RIDX_W'($urandom));
    read_written_byte();

    n_total = issue_q.size();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (n_retired < n_total) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (retire_q.size() != 0) begin
      errors++;
      $display("%0t: %0d output words never arrived", $time, retire_q.size());
    end
    $display("covered %0d words: %0d instructions, %0d byte writes, %0d byte reads, %0d reg reads",
             n_total, n_op[OP_EXEC], n_op[OP_WR_BYTE], n_op[OP_RD_BYTE], n_op[OP_RD_REG]);
    $display("%0d branches taken, %0d register writes, halted %0d", n_taken, n_writes, halted_m);
    if (errors == 0) begin
      $display("rv32i_subset_instruction_executor: match");
    end else begin
      $display("rv32i_subset_instruction_executor: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("rv32i_subset_instruction_executor: mismatch");
    $finish;
  end

endmodule
